@@ hw/rtl/hps_pkg.sv @@
// Shared types, constants and codes of the H-pattern shifter gear select block.
package hps_pkg;

	localparam int AREA_W    = 12;
	localparam int GEARS_W   = 4;
	localparam int DELTA_W   = 11;
	localparam int OUT_POS_W = 13;
	localparam int GEAR_W    = 4;
	localparam int POS_W     = 17;
	localparam int GSP_W     = 12;
	localparam int GW_W      = 13;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 12;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 40;

	localparam int MAX_GATES = 16;
	localparam int GATE_CAP  = (MAX_GATES < 16) ? MAX_GATES : 16;
	localparam int GATE_N_W  = 5;

	// floor(x/100) and floor(x/3) for any 12-bit x: multiply by the rounded-up
	// reciprocal, then shift right.
	localparam int                 RECIP_W       = 15;
	localparam logic [RECIP_W-1:0] SPACING_RECIP = RECIP_W'(5243);
	localparam int                 SPACING_SHIFT = 19;
	localparam logic [RECIP_W-1:0] HEIGHT_RECIP  = RECIP_W'(21846);
	localparam int                 HEIGHT_SHIFT  = 16;

	localparam logic [AREA_W-1:0]  AREA_WIDTH_RST    = AREA_W'(1280);
	localparam logic [AREA_W-1:0]  AREA_HEIGHT_RST   = AREA_W'(720);
	localparam logic [GEARS_W-1:0] FORWARD_GEARS_RST = GEARS_W'(6);

	localparam logic [CFG_IDX_W-1:0] CFG_AREA_WIDTH      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AREA_HEIGHT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_GEARS   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SIDE_LIMITS_OFF = 2'd3;

	localparam logic OP_MOVE = 1'b0;
	localparam logic OP_INIT = 1'b1;

	localparam logic [GEAR_W-1:0] GEAR_NEUTRAL = 4'd0;

	typedef logic signed [POS_W-1:0] pos_t;

	typedef struct packed {
		pos_t x0;
		pos_t x1;
		pos_t y0;
		pos_t y1;
	} rect_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_S,
		ST_DIV_W,
		ST_DIV_H,
		ST_SCAN,
		ST_DONE
	} hps_state_t;

endpackage

@@ hw/rtl/h_pattern_shifter_gear_select.sv @@
// Top level of the H-pattern shifter: sequencer, layout state and output register.
// Move: accept, test 1 to 16 gates in index order, stopping at the first hit, then commit;
//   no new input is taken until the result is committed.
// Init: spacing and height by reciprocal multiply, gate width on the 12-step divider;
//   no new input until the commit. A stalled result holds the commit cycle.
// Reset (arst_n low, asynchronous): registers at reset values, handle at origin, neutral.
module h_pattern_shifter_gear_select (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [hps_pkg::IN_DATA_W-1:0]       s_tdata,   // delta_x[10:0], delta_y[21:11]
	input  logic [0:0]                          s_tuser,   // op
	// Result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// handle_x[12:0], handle_y[25:13], gear[29:26], release_valid[30],
	// release_button[34:31], press_valid[35], press_button[39:36]
	output logic [hps_pkg::OUT_DATA_W-1:0]      m_tdata,
	// Configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [hps_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [hps_pkg::CFG_DAT_W-1:0]       cfg_data
);
	import hps_pkg::*;

	// Configuration registers
	logic [AREA_W-1:0]  area_width_q;
	logic [AREA_W-1:0]  area_height_q;
	logic [GEARS_W-1:0] forward_gears_q;
	logic               side_limits_off_q;

	// Sequencer
	hps_state_t state_q, state_d;
	logic       div_start;
	logic       div_run_q;
	logic       out_free;

	// Handle and layout state
	pos_t              pos_x_q, pos_y_q;
	logic [GEAR_W-1:0] active_q;
	logic [GSP_W-1:0]  gsp_q;
	logic signed [GW_W-1:0] gw_q;
	logic [AREA_W-1:0] gh_q;

	// Per-transaction working registers
	logic              op_q;
	pos_t              nx_q, ny_q;
	logic [GEAR_W-1:0] idx_q;
	pos_t              xacc_q;
	logic              hit_q;
	logic [GEAR_W-1:0] hit_idx_q;

	// Result register
	logic                 m_tvalid_q;
	logic [OUT_POS_W-1:0] out_x_q, out_y_q;
	logic [GEAR_W-1:0]    out_gear_q, out_rel_b_q, out_prs_b_q;
	logic                 out_rel_v_q, out_prs_v_q;

	// Divider hookup
	logic [AREA_W-1:0] div_dividend, div_divisor, div_quo;
	logic              div_busy, div_done;

	// Reciprocal multiplier for the constant divisions
	logic [AREA_W-1:0]         recip_a;
	logic [RECIP_W-1:0]        recip_b;
	logic [AREA_W+RECIP_W-1:0] recip_prod;

	// Layout helpers
	logic [GATE_N_W-1:0] gate_sum, gate_n;
	logic [GEAR_W-1:0]   gate_half;
	pos_t w_p, s_p, gw_p, gh_p, gh2_p, gh3_p, pitch_p;
	rect_t rect;
	logic  rect_hit;
	logic  scan_last;
	logic signed [DELTA_W-1:0] in_dx, in_dy;
	pos_t  clamp_x, clamp_y;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_width_q      <= AREA_WIDTH_RST;
			area_height_q     <= AREA_HEIGHT_RST;
			forward_gears_q   <= FORWARD_GEARS_RST;
			side_limits_off_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_AREA_WIDTH:      area_width_q      <= cfg_data[AREA_W-1:0];
				CFG_AREA_HEIGHT:     area_height_q     <= cfg_data[AREA_W-1:0];
				CFG_FORWARD_GEARS:   forward_gears_q   <= cfg_data[GEARS_W-1:0];
				CFG_SIDE_LIMITS_OFF: side_limits_off_q <= cfg_data[0];
			endcase
		end
	end

	// Gate count saturates so the index fits the gear field.
	always_comb begin
		gate_sum  = {1'b0, forward_gears_q} + GATE_N_W'(2);
		gate_n    = (gate_sum > GATE_N_W'(GATE_CAP)) ? GATE_N_W'(GATE_CAP) : gate_sum;
		gate_half = gate_n[GATE_N_W-1:1];
	end

	always_comb begin
		w_p     = $signed({{(POS_W-AREA_W){1'b0}}, area_width_q});
		s_p     = $signed({{(POS_W-GSP_W){1'b0}}, gsp_q});
		gw_p    = {{(POS_W-GW_W){gw_q[GW_W-1]}}, gw_q};
		gh_p    = $signed({{(POS_W-AREA_W){1'b0}}, gh_q});
		gh2_p   = gh_p <<< 1;
		gh3_p   = gh2_p + gh_p;
		pitch_p = gw_p + (s_p <<< 1);
	end

	// Rectangle of the gate under test: neutral band, reverse slot, or a forward
	// slot whose left edge walks right by one pitch per pair of gates.
	always_comb begin
		if (idx_q == GEAR_NEUTRAL) begin
			rect.x0 = '0;
			rect.x1 = w_p;
			rect.y0 = gh_p;
			rect.y1 = gh2_p;
		end else if (idx_q == GEAR_W'(1)) begin
			rect.x0 = w_p - gw_p - s_p;
			rect.x1 = w_p - s_p;
			rect.y0 = gh2_p;
			rect.y1 = gh3_p;
		end else begin
			rect.x0 = xacc_q;
			rect.x1 = xacc_q + gw_p;
			rect.y0 = idx_q[0] ? gh2_p : '0;
			rect.y1 = idx_q[0] ? gh3_p : gh_p;
		end
	end

	hps_rect_hit u_rect_hit (
		.rect (rect),
		.px   (nx_q),
		.py   (ny_q),
		.hit  (rect_hit)
	);

	assign scan_last = ({1'b0, idx_q} == (gate_n - GATE_N_W'(1)));

	// Spacing (width / 100) and gate height (height / 3) by reciprocal multiply.
	always_comb begin
		recip_a    = (state_q == ST_DIV_H) ? area_height_q : area_width_q;
		recip_b    = (state_q == ST_DIV_H) ? HEIGHT_RECIP : SPACING_RECIP;
		recip_prod = {{RECIP_W{1'b0}}, recip_a} * {{AREA_W{1'b0}}, recip_b};
	end

	// The divider only splits the width over half the gate count.
	assign div_dividend = area_width_q;
	assign div_divisor  = {{(AREA_W-GEAR_W){1'b0}}, gate_half};

	hps_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quo),
		.busy     (div_busy),
		.done     (div_done)
	);

	assign out_free = !m_tvalid_q || m_tready;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = (s_tuser[0] == OP_INIT) ? ST_DIV_S : ST_SCAN;
				end
			end
			ST_DIV_S: begin
				state_d = ST_DIV_W;
			end
			ST_DIV_W: begin
				div_start = !div_run_q;
				if (div_done) begin
					state_d = ST_DIV_H;
				end
			end
			ST_DIV_H: begin
				state_d = ST_DONE;
			end
			ST_SCAN: begin
				if (rect_hit || scan_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_run_q <= 1'b0;
		end else if (div_start) begin
			div_run_q <= 1'b1;
		end else if (div_done) begin
			div_run_q <= 1'b0;
		end
	end

	assign in_dx = s_tdata[DELTA_W-1:0];
	assign in_dy = s_tdata[2*DELTA_W-1:DELTA_W];

	// Working registers: capture the moved point, walk the gates.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			op_q   <= s_tuser[0];
			nx_q   <= pos_x_q + {{(POS_W-DELTA_W){in_dx[DELTA_W-1]}}, in_dx};
			ny_q   <= pos_y_q + {{(POS_W-DELTA_W){in_dy[DELTA_W-1]}}, in_dy};
			idx_q  <= GEAR_NEUTRAL;
			xacc_q <= s_p;
			hit_q  <= 1'b0;
		end else if (state_q == ST_SCAN) begin
			if (rect_hit || scan_last) begin
				hit_q     <= rect_hit;
				hit_idx_q <= idx_q;
			end else begin
				idx_q <= idx_q + GEAR_W'(1);
				// Advance the slot edge after the odd gate of each forward pair.
				if (idx_q[0] && idx_q != GEAR_W'(1)) begin
					xacc_q <= xacc_q + pitch_p;
				end
			end
		end
	end

	always_comb begin
		clamp_x = nx_q;
		if (nx_q < 0) begin
			clamp_x = '0;
		end else if (nx_q > w_p) begin
			clamp_x = w_p;
		end
		clamp_y = ny_q;
		if (ny_q < 0) begin
			clamp_y = '0;
		end else if (ny_q > $signed({{(POS_W-AREA_W){1'b0}}, area_height_q})) begin
			clamp_y = $signed({{(POS_W-AREA_W){1'b0}}, area_height_q});
		end
	end

	// Handle and layout state; layout values latch one step at a time during init.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q  <= '0;
			pos_y_q  <= '0;
			active_q <= GEAR_NEUTRAL;
			gsp_q    <= '0;
			gw_q     <= '0;
			gh_q     <= '0;
		end else begin
			if (state_q == ST_DIV_S) begin
				gsp_q <= GSP_W'(recip_prod >> SPACING_SHIFT);
			end
			if (state_q == ST_DIV_W && div_done) begin
				gw_q <= $signed({1'b0, div_quo}) - $signed({gsp_q[GSP_W-1:0], 1'b0});
			end
			if (state_q == ST_DIV_H) begin
				gh_q <= AREA_W'(recip_prod >> HEIGHT_SHIFT);
			end
			if (state_q == ST_DONE && out_free) begin
				if (op_q == OP_INIT) begin
					pos_x_q <= w_p >>> 1;
					pos_y_q <= gh_p + (gh_p >>> 1);
				end else begin
					if (hit_q) begin
						active_q <= hit_idx_q;
					end
					if (side_limits_off_q) begin
						pos_x_q <= clamp_x;
						pos_y_q <= clamp_y;
					end else if (hit_q) begin
						pos_x_q <= nx_q;
						pos_y_q <= ny_q;
					end
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_rel_v_q <= 1'b0;
			out_rel_b_q <= '0;
			out_prs_v_q <= 1'b0;
			out_prs_b_q <= '0;
			if (op_q == OP_INIT) begin
				out_x_q    <= OUT_POS_W'(w_p >>> 1);
				out_y_q    <= OUT_POS_W'(gh_p + (gh_p >>> 1));
				out_gear_q <= active_q;
			end else begin
				out_gear_q <= hit_q ? hit_idx_q : active_q;
				if (side_limits_off_q) begin
					out_x_q <= clamp_x[OUT_POS_W-1:0];
					out_y_q <= clamp_y[OUT_POS_W-1:0];
				end else if (hit_q) begin
					out_x_q <= nx_q[OUT_POS_W-1:0];
					out_y_q <= ny_q[OUT_POS_W-1:0];
				end else begin
					out_x_q <= pos_x_q[OUT_POS_W-1:0];
					out_y_q <= pos_y_q[OUT_POS_W-1:0];
				end
				// Gear change: release the old button, press the new; neutral has none.
				if (hit_q && hit_idx_q != active_q) begin
					if (active_q != GEAR_NEUTRAL) begin
						out_rel_v_q <= 1'b1;
						out_rel_b_q <= active_q - GEAR_W'(1);
					end
					if (hit_idx_q != GEAR_NEUTRAL) begin
						out_prs_v_q <= 1'b1;
						out_prs_b_q <= hit_idx_q - GEAR_W'(1);
					end
				end
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_prs_b_q, out_prs_v_q, out_rel_b_q, out_rel_v_q,
		out_gear_q, out_y_q, out_x_q};

	// A pressed button always names the gear reported with it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && out_prs_v_q) |-> (out_gear_q == out_prs_b_q + GEAR_W'(1)))
		else $error("press button does not match reported gear");

	// A released button is never the gear just reported.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && out_rel_v_q) |-> (out_gear_q != out_rel_b_q + GEAR_W'(1)))
		else $error("released button equals reported gear");

	// The divider is only started while it is idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while busy");

	// The gate walk never runs past the configured gate count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> ({1'b0, idx_q} < gate_n))
		else $error("gate index beyond gate count");

	// An input is taken only while no transaction is in flight.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_SCAN || state_q == ST_DIV_S))
		else $error("accepted transaction did not start work");

endmodule

@@ hw/rtl/hps_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module hps_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [hps_pkg::AREA_W-1:0] dividend,
	input  logic [hps_pkg::AREA_W-1:0] divisor,
	output logic [hps_pkg::AREA_W-1:0] quotient,
	output logic                       busy,
	output logic                       done
);
	import hps_pkg::*;

	localparam int CNT_W = $clog2(AREA_W + 1);

	logic [AREA_W-1:0] quo_q;
	logic [AREA_W-1:0] rem_q;
	logic [AREA_W-1:0] dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [AREA_W:0]   shifted;
	logic [AREA_W+1:0] trial;
	logic              q_bit;

	always_comb begin
		shifted = {rem_q, quo_q[AREA_W-1]};
		trial   = {1'b0, shifted} - {2'b00, dvs_q};
		q_bit   = ~trial[AREA_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(AREA_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder stays below the divisor, so the low bits hold it.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[AREA_W-2:0], q_bit};
			rem_q <= q_bit ? trial[AREA_W-1:0] : shifted[AREA_W-1:0];
		end
	end

	assign quotient = quo_q;
	assign busy     = busy_q;
	assign done     = done_q;

endmodule

@@ hw/rtl/hps_rect_hit.sv @@
// Point-in-rectangle test, edges inclusive.
module hps_rect_hit (
	input  hps_pkg::rect_t rect,
	input  hps_pkg::pos_t  px,
	input  hps_pkg::pos_t  py,
	output logic           hit
);
	import hps_pkg::*;

	assign hit = (rect.x0 <= px) && (px <= rect.x1) && (rect.y0 <= py) && (py <= rect.y1);

endmodule
